@@ rtl/mersenne_twister_64_assert.svh @@
// Assertion macros used by the controller of the generator.
`ifndef MERSENNE_TWISTER_64_ASSERT_SVH
`define MERSENNE_TWISTER_64_ASSERT_SVH

// Same-cycle implication.
`define MT64_ASSERT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define MT64_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/mt64_pkg.sv @@
`default_nettype none
package mt64_pkg;

   // Table geometry
   localparam int STATE_WORDS = 312;
   localparam int KEY_WORDS   = 16;
   localparam int HALF_WORDS  = STATE_WORDS / 2;
   localparam int KEY_STEPS   = (STATE_WORDS > KEY_WORDS) ? STATE_WORDS : KEY_WORDS;

   localparam int IDX_W  = $clog2(STATE_WORDS);
   localparam int RIDX_W = $clog2(STATE_WORDS + 1);
   localparam int KCNT_W = $clog2(KEY_WORDS + 1);
   localparam int KIDX_W = (KEY_WORDS > 1) ? $clog2(KEY_WORDS) : 1;
   localparam int STEP_W = $clog2(KEY_STEPS + 1);
   localparam int KIND_W = 2;

   // Item kinds
   localparam logic [KIND_W-1:0] KIND_SEED = 2'd0;
   localparam logic [KIND_W-1:0] KIND_KEY  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_DRAW = 2'd2;

   // Algorithm constants
   localparam logic [63:0] SEED_MULT    = 64'd6364136223846793005;
   localparam logic [63:0] KEY_MULT     = 64'd3935559000370003845;
   localparam logic [63:0] MIX_MULT     = 64'd2862933555777941757;
   localparam logic [63:0] ARRAY_SEED   = 64'd19650218;
   localparam logic [63:0] TOP_BIT      = 64'h8000000000000000;
   localparam logic [63:0] UPPER_MASK   = 64'hFFFFFFFF80000000;
   localparam logic [63:0] LOWER_MASK   = 64'h000000007FFFFFFF;
   localparam logic [63:0] TWIST_MATRIX = 64'hB5026F5AA96619E9;
   localparam logic [63:0] TEMPER_B     = 64'h5555555555555555;
   localparam logic [63:0] TEMPER_C     = 64'h71D67FFFEDA60000;
   localparam logic [63:0] TEMPER_D     = 64'hFFF7EEE000000000;

   // Multiplier phases
   localparam logic [2:0] MUL_NONE = 3'd0;
   localparam logic [2:0] MUL_P0   = 3'd1;
   localparam logic [2:0] MUL_P1   = 3'd2;
   localparam logic [2:0] MUL_P2   = 3'd3;
   localparam logic [2:0] MUL_P3   = 3'd4;

   // Multiplier constant and finish-step select
   localparam logic [1:0] CSEL_SEED = 2'd0;
   localparam logic [1:0] CSEL_KEY  = 2'd1;
   localparam logic [1:0] CSEL_MIX  = 2'd2;

   // Table write data select
   localparam logic [2:0] WSEL_VALUE  = 3'd0;
   localparam logic [2:0] WSEL_ARRAY  = 3'd1;
   localparam logic [2:0] WSEL_RESULT = 3'd2;
   localparam logic [2:0] WSEL_PREV   = 3'd3;
   localparam logic [2:0] WSEL_TOP    = 3'd4;
   localparam logic [2:0] WSEL_TWIST  = 3'd5;

   // Previous-word register select
   localparam logic [1:0] PSEL_HOLD   = 2'd0;
   localparam logic [1:0] PSEL_VALUE  = 2'd1;
   localparam logic [1:0] PSEL_ARRAY  = 2'd2;
   localparam logic [1:0] PSEL_RESULT = 2'd3;

   // Controller to datapath commands
   typedef struct packed {
      logic              rd_a_en;
      logic [IDX_W-1:0]  rd_a_addr;
      logic              rd_b_en;
      logic [IDX_W-1:0]  rd_b_addr;
      logic              wr_en;
      logic [IDX_W-1:0]  wr_addr;
      logic [2:0]        wr_sel;
      logic [1:0]        prev_sel;
      logic [2:0]        mul_op;
      logic [1:0]        csel;
      logic [KIDX_W-1:0] key_idx;
      logic              key_wr_en;
      logic              cur_load;
      logic              out_load;
   } cmd_type;

endpackage
`default_nettype wire

@@ rtl/mt64_if.sv @@
`default_nettype none
// Request channel: one seed, key word or draw per item.
interface mt64_req_if;
   import mt64_pkg::*;
   logic              valid;
   logic              ready;
   logic [KIND_W-1:0] kind;
   logic [63:0]       value;
   logic              last_key;
   modport source (output valid, kind, value, last_key, input ready);
   modport sink   (input valid, kind, value, last_key, output ready);
endinterface

// Response channel: one tempered word per draw.
interface mt64_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] random_word;
   modport source (output valid, random_word, input ready);
   modport sink   (input valid, random_word, output ready);
endinterface
`default_nettype wire

@@ rtl/mersenne_twister_64.sv @@
`default_nettype none
// 64-bit Mersenne Twister (mt19937_64) with a 312-word state table held in a
// memory with one write and two registered read ports. A seed item fills the
// table one word at a time, each through the shared 32x32 multiplier that
// builds each 64-bit product in three partial products. The final key word of
// an array seed runs the seed fill, then 312 and 311 mixing steps. A draw
// returns one tempered table word; on every 312th draw (and the first after a
// seed) the table twist runs first, which updates one entry at a time. The
// block takes one item at a time; a finished word waits in the output register
// while the next item is accepted. Draws before the first seed return
// undefined words.
module mersenne_twister_64 (
   input wire logic clock,
   input wire logic reset,
   mt64_req_if.sink   req_if,
   mt64_rsp_if.source rsp_if
);
   import mt64_pkg::*;

   cmd_type cmd;

   mt64_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_if.valid),
      .req_ready    (req_if.ready),
      .req_kind     (req_if.kind),
      .req_last_key (req_if.last_key),
      .rsp_valid    (rsp_if.valid),
      .rsp_ready    (rsp_if.ready),
      .cmd          (cmd)
   );

   mt64_datapath u_datapath (
      .clock     (clock),
      .cmd       (cmd),
      .req_value (req_if.value),
      .rsp_word  (rsp_if.random_word)
   );

endmodule
`default_nettype wire

@@ rtl/mt64_datapath.sv @@
`default_nettype none
module mt64_datapath (
   input  wire logic             clock,
   input  wire mt64_pkg::cmd_type cmd,
   input  wire logic [63:0]      req_value,
   output logic [63:0]           rsp_word
);
   import mt64_pkg::*;

   logic [63:0] state_mem [STATE_WORDS];
   logic [63:0] key_buf_ff [KEY_WORDS];
   logic [63:0] rd_a_ff, rd_b_ff;
   logic [63:0] prev_ff, prev_in;
   logic [63:0] cur_ff;
   logic [63:0] mul_ff, acc_ff, acc_in;
   logic [63:0] out_ff;
   logic [63:0] x_word, mconst, result, wdata, mix, twisted;
   logic [31:0] mul_a, mul_b;

   function automatic logic [63:0] temper(input logic [63:0] v);
      logic [63:0] y;
      y = v ^ ((v >> 29) & TEMPER_B);
      y = y ^ ((y << 17) & TEMPER_C);
      y = y ^ ((y << 37) & TEMPER_D);
      y = y ^ (y >> 43);
      return y;
   endfunction

   // Multiplier operand: prev ^ (prev >> 62)
   assign x_word = prev_ff ^ (prev_ff >> 62);

   always_comb begin
      case (cmd.csel)
         CSEL_KEY: mconst = KEY_MULT;
         CSEL_MIX: mconst = MIX_MULT;
         default:  mconst = SEED_MULT;
      endcase
   end

   // 64x64 low product from three 32x32 partial products
   always_comb begin
      case (cmd.mul_op)
         MUL_P1:  begin mul_a = x_word[63:32]; mul_b = mconst[31:0];  end
         MUL_P2:  begin mul_a = x_word[31:0];  mul_b = mconst[63:32]; end
         default: begin mul_a = x_word[31:0];  mul_b = mconst[31:0];  end
      endcase
   end

   always_comb begin
      case (cmd.mul_op)
         MUL_P1:         acc_in = mul_ff;
         MUL_P2, MUL_P3: acc_in = acc_ff + {mul_ff[31:0], 32'h0};
         default:        acc_in = acc_ff;
      endcase
   end

   // Finish step of one initialization word
   always_comb begin
      case (cmd.csel)
         CSEL_KEY: result = (rd_a_ff ^ acc_ff) + key_buf_ff[cmd.key_idx]
                            + 64'(cmd.key_idx);
         CSEL_MIX: result = (rd_a_ff ^ acc_ff) - 64'(cmd.wr_addr);
         default:  result = acc_ff + 64'(cmd.wr_addr);
      endcase
   end

   // Twist of one entry
   assign mix     = (cur_ff & UPPER_MASK) | (rd_a_ff & LOWER_MASK);
   assign twisted = rd_b_ff ^ (mix >> 1) ^ (mix[0] ? TWIST_MATRIX : 64'h0);

   always_comb begin
      case (cmd.wr_sel)
         WSEL_VALUE:  wdata = req_value;
         WSEL_ARRAY:  wdata = ARRAY_SEED;
         WSEL_RESULT: wdata = result;
         WSEL_PREV:   wdata = prev_ff;
         WSEL_TOP:    wdata = TOP_BIT;
         WSEL_TWIST:  wdata = twisted;
         default:     wdata = result;
      endcase
   end

   always_comb begin
      case (cmd.prev_sel)
         PSEL_VALUE:  prev_in = req_value;
         PSEL_ARRAY:  prev_in = ARRAY_SEED;
         PSEL_RESULT: prev_in = result;
         default:     prev_in = prev_ff;
      endcase
   end

   // Data registers
   always_ff @(posedge clock) begin
      prev_ff <= prev_in;
      acc_ff  <= acc_in;
      if (cmd.mul_op != MUL_NONE) begin
         mul_ff <= mul_a * mul_b;
      end
      if (cmd.cur_load) begin
         cur_ff <= rd_a_ff;
      end
      if (cmd.out_load) begin
         out_ff <= temper(rd_a_ff);
      end
      if (cmd.key_wr_en) begin
         key_buf_ff[cmd.key_idx] <= req_value;
      end
   end

   // State table: one write port, two registered read ports
   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         state_mem[cmd.wr_addr] <= wdata;
      end
      if (cmd.rd_a_en) begin
         rd_a_ff <= state_mem[cmd.rd_a_addr];
      end
      if (cmd.rd_b_en) begin
         rd_b_ff <= state_mem[cmd.rd_b_addr];
      end
   end

   assign rsp_word = out_ff;

endmodule
`default_nettype wire

@@ rtl/mt64_ctrl.sv @@
`default_nettype none
`include "mersenne_twister_64_assert.svh"
module mt64_ctrl (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire logic [mt64_pkg::KIND_W-1:0] req_kind,
   input  wire logic                      req_last_key,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output mt64_pkg::cmd_type              cmd
);
   import mt64_pkg::*;

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_M0       = 4'd1;
   localparam logic [3:0] S_M1       = 4'd2;
   localparam logic [3:0] S_M2       = 4'd3;
   localparam logic [3:0] S_M3       = 4'd4;
   localparam logic [3:0] S_FIN      = 4'd5;
   localparam logic [3:0] S_KRD      = 4'd6;
   localparam logic [3:0] S_WRAP     = 4'd7;
   localparam logic [3:0] S_TOP      = 4'd8;
   localparam logic [3:0] S_TW_PRE   = 4'd9;
   localparam logic [3:0] S_TW_LD    = 4'd10;
   localparam logic [3:0] S_TW_RD    = 4'd11;
   localparam logic [3:0] S_TW_WR    = 4'd12;
   localparam logic [3:0] S_DRAW_RD  = 4'd13;
   localparam logic [3:0] S_DRAW_OUT = 4'd14;

   localparam logic [1:0] MODE_SEED = 2'd0;
   localparam logic [1:0] MODE_KEY  = 2'd1;
   localparam logic [1:0] MODE_MIX  = 2'd2;
   localparam logic [1:0] MODE_DONE = 2'd3;

   localparam logic [IDX_W-1:0] LAST_POS = IDX_W'(STATE_WORDS - 1);

   logic [3:0]        state_ff, state_in;
   logic [1:0]        mode_ff, mode_in;
   logic [IDX_W-1:0]  pos_ff, pos_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [KIDX_W-1:0] kidx_ff, kidx_in;
   logic [KCNT_W-1:0] nkeys_ff, nkeys_in;
   logic [KCNT_W-1:0] key_count_ff, key_count_in;
   logic [RIDX_W-1:0] read_index_ff, read_index_in;
   logic              keys_pending_ff, keys_pending_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [KCNT_W-1:0] count_next, kidx_inc;
   logic              out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign kidx_inc = KCNT_W'(kidx_ff) + KCNT_W'(1);

   // Next-state and command decode
   always_comb begin
      state_in        = state_ff;
      mode_in         = mode_ff;
      pos_in          = pos_ff;
      step_in         = step_ff;
      kidx_in         = kidx_ff;
      nkeys_in        = nkeys_ff;
      key_count_in    = key_count_ff;
      read_index_in   = read_index_ff;
      keys_pending_in = keys_pending_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      count_next      = key_count_ff;
      req_ready       = 1'b0;
      cmd             = '0;
      cmd.csel        = (mode_ff == MODE_KEY) ? CSEL_KEY :
                        (mode_ff == MODE_MIX) ? CSEL_MIX : CSEL_SEED;
      cmd.key_idx     = kidx_ff;

      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               case (req_kind)
                  KIND_SEED: begin
                     cmd.wr_en       = 1'b1;
                     cmd.wr_addr     = '0;
                     cmd.wr_sel      = WSEL_VALUE;
                     cmd.prev_sel    = PSEL_VALUE;
                     pos_in          = IDX_W'(1);
                     mode_in         = MODE_SEED;
                     read_index_in   = RIDX_W'(STATE_WORDS);
                     keys_pending_in = 1'b0;
                     state_in        = S_M0;
                  end
                  KIND_KEY: begin
                     if (key_count_ff < KCNT_W'(KEY_WORDS)) begin
                        cmd.key_wr_en = 1'b1;
                        cmd.key_idx   = key_count_ff[KIDX_W-1:0];
                        count_next    = key_count_ff + KCNT_W'(1);
                     end
                     key_count_in = count_next;
                     if (req_last_key) begin
                        key_count_in    = '0;
                        nkeys_in        = (count_next == '0) ? KCNT_W'(1) : count_next;
                        cmd.wr_en       = 1'b1;
                        cmd.wr_addr     = '0;
                        cmd.wr_sel      = WSEL_ARRAY;
                        cmd.prev_sel    = PSEL_ARRAY;
                        pos_in          = IDX_W'(1);
                        mode_in         = MODE_SEED;
                        read_index_in   = RIDX_W'(STATE_WORDS);
                        keys_pending_in = 1'b1;
                        state_in        = S_M0;
                     end
                  end
                  KIND_DRAW: begin
                     if (read_index_ff >= RIDX_W'(STATE_WORDS)) begin
                        pos_in   = '0;
                        state_in = S_TW_PRE;
                     end else begin
                        state_in = S_DRAW_RD;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_M0: begin
            cmd.mul_op = MUL_P0;
            state_in   = S_M1;
         end
         S_M1: begin
            cmd.mul_op = MUL_P1;
            state_in   = S_M2;
         end
         S_M2: begin
            cmd.mul_op = MUL_P2;
            state_in   = S_M3;
         end
         S_M3: begin
            cmd.mul_op = MUL_P3;
            state_in   = S_FIN;
         end
         S_FIN: begin
            cmd.wr_en    = 1'b1;
            cmd.wr_addr  = pos_ff;
            cmd.wr_sel   = WSEL_RESULT;
            cmd.prev_sel = PSEL_RESULT;
            if (mode_ff == MODE_SEED) begin
               if (pos_ff == LAST_POS) begin
                  if (keys_pending_ff) begin
                     // table seeded; start mixing in the key words
                     keys_pending_in = 1'b0;
                     mode_in         = MODE_KEY;
                     pos_in          = IDX_W'(1);
                     cmd.prev_sel    = PSEL_ARRAY;
                     kidx_in         = '0;
                     step_in         = STEP_W'(KEY_STEPS);
                     state_in        = S_KRD;
                  end else begin
                     state_in = S_IDLE;
                  end
               end else begin
                  pos_in   = pos_ff + IDX_W'(1);
                  state_in = S_M0;
               end
            end else begin
               if (mode_ff == MODE_KEY) begin
                  kidx_in = (kidx_inc >= nkeys_ff) ? '0 : kidx_inc[KIDX_W-1:0];
               end
               step_in = step_ff - STEP_W'(1);
               if (step_ff == STEP_W'(1)) begin
                  if (mode_ff == MODE_KEY) begin
                     mode_in = MODE_MIX;
                     step_in = STEP_W'(STATE_WORDS - 1);
                  end else begin
                     mode_in = MODE_DONE;
                  end
               end
               if (pos_ff == LAST_POS) begin
                  state_in = S_WRAP;
               end else begin
                  pos_in   = pos_ff + IDX_W'(1);
                  state_in = (mode_in == MODE_DONE) ? S_TOP : S_KRD;
               end
            end
         end
         S_WRAP: begin
            // entry 0 takes the last entry, position restarts at 1
            cmd.wr_en   = 1'b1;
            cmd.wr_addr = '0;
            cmd.wr_sel  = WSEL_PREV;
            pos_in      = IDX_W'(1);
            state_in    = (mode_ff == MODE_DONE) ? S_TOP : S_KRD;
         end
         S_KRD: begin
            cmd.rd_a_en   = 1'b1;
            cmd.rd_a_addr = pos_ff;
            state_in      = S_M0;
         end
         S_TOP: begin
            cmd.wr_en   = 1'b1;
            cmd.wr_addr = '0;
            cmd.wr_sel  = WSEL_TOP;
            state_in    = S_IDLE;
         end
         S_TW_PRE: begin
            cmd.rd_a_en   = 1'b1;
            cmd.rd_a_addr = '0;
            state_in      = S_TW_LD;
         end
         S_TW_LD: begin
            cmd.cur_load = 1'b1;
            state_in     = S_TW_RD;
         end
         S_TW_RD: begin
            cmd.rd_a_en   = 1'b1;
            cmd.rd_a_addr = (pos_ff == LAST_POS) ? '0 : pos_ff + IDX_W'(1);
            cmd.rd_b_en   = 1'b1;
            cmd.rd_b_addr = (pos_ff >= IDX_W'(HALF_WORDS)) ? pos_ff - IDX_W'(HALF_WORDS)
                                                           : pos_ff + IDX_W'(HALF_WORDS);
            state_in      = S_TW_WR;
         end
         S_TW_WR: begin
            cmd.wr_en    = 1'b1;
            cmd.wr_addr  = pos_ff;
            cmd.wr_sel   = WSEL_TWIST;
            cmd.cur_load = 1'b1;
            if (pos_ff == LAST_POS) begin
               read_index_in = '0;
               state_in      = S_DRAW_RD;
            end else begin
               pos_in   = pos_ff + IDX_W'(1);
               state_in = S_TW_RD;
            end
         end
         S_DRAW_RD: begin
            cmd.rd_a_en   = 1'b1;
            cmd.rd_a_addr = read_index_ff[IDX_W-1:0];
            state_in      = S_DRAW_OUT;
         end
         S_DRAW_OUT: begin
            if (out_free) begin
               cmd.out_load  = 1'b1;
               rsp_valid_in  = 1'b1;
               read_index_in = read_index_ff + RIDX_W'(1);
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         mode_ff         <= MODE_SEED;
         pos_ff          <= '0;
         step_ff         <= '0;
         kidx_ff         <= '0;
         nkeys_ff        <= KCNT_W'(1);
         key_count_ff    <= '0;
         read_index_ff   <= RIDX_W'(STATE_WORDS);
         keys_pending_ff <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         mode_ff         <= mode_in;
         pos_ff          <= pos_in;
         step_ff         <= step_in;
         kidx_ff         <= kidx_in;
         nkeys_ff        <= nkeys_in;
         key_count_ff    <= key_count_in;
         read_index_ff   <= read_index_in;
         keys_pending_ff <= keys_pending_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   `MT64_ASSERT(a_pos_range, clock, reset, 1'b1, pos_ff < IDX_W'(STATE_WORDS), "table position out of range")
   `MT64_ASSERT(a_key_count, clock, reset, 1'b1, key_count_ff <= KCNT_W'(KEY_WORDS), "key count overflow")
   `MT64_ASSERT(a_draw_no_write, clock, reset, (state_ff == S_DRAW_RD) || (state_ff == S_DRAW_OUT), !cmd.wr_en, "draw wrote the state table")
   `MT64_ASSERT_NEXT(a_draw_issue, clock, reset, (state_ff == S_DRAW_OUT) && out_free, rsp_valid_ff && (read_index_ff == $past(read_index_ff) + RIDX_W'(1)), "draw did not present a word")

endmodule
`default_nettype wire
